FILE: rtl/assert_macros.svh
// Assertion macros shared by the ordered list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define OLE_CHECK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ordered list check failed");
`define OLE_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ordered list forbidden condition");
`else
`define OLE_CHECK(lbl, clk, rst_n, prop)
`define OLE_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/olist_pkg.sv
// Types and constants of the ordered list engine.
package olist_pkg;

  localparam int unsigned OP_W       = 4;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned TDATA_IN_W = 40;
  localparam int unsigned TDATA_OUT_W = 40;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_AW       = 1;
  localparam int unsigned Q_CW       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_END   = 4'd0,
    OP_INS_BEGIN = 4'd1,
    OP_INS_POS   = 4'd2,
    OP_DEL_FIRST = 4'd3,
    OP_DEL_LAST  = 4'd4,
    OP_DEL_POS   = 4'd5,
    OP_COUNT     = 4'd6,
    OP_SEARCH    = 4'd7,
    OP_DUMP      = 4'd8,
    OP_CLEAR     = 4'd9
  } opcode_t;

  typedef enum logic [3:0] {
    K_INS_END,
    K_INS_BEGIN,
    K_INS_POS,
    K_DEL_FIRST,
    K_DEL_LAST,
    K_DEL_POS,
    K_SEARCH,
    K_DUMP,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                   kind;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] element_value;
    logic [CNT_W-1:0]        element_count;
    logic                    found;
    logic                    last_of_run;
  } res_t;

endpackage

FILE: rtl/ordered_list_engine_core.sv
// Top level of the ordered list engine: front decoder/queue and back cell row.
//
//  port group | dir | tdata (low bit up)                      | tuser  | tlast
//  in_*       | in  | position[4:0], value[36:5], zero pad    | opcode | -
//  out_*      | out | status[1:0], element_value[33:2],       | -      | last_of_run
//             |     | element_count[38:34], found[39]         |        |
//
// Insert, count, clear and rejected commands: finished in the accept step.
// Delete first: accept, then pop; other deletes: accept, rotate to the target,
// pop, rotate back over the cell row where needed.
// Search and dump: accept, then one rotation of the cell row per cycle while the result register is free.
// A two-word command queue sits between front and back; results leave from a register.
// The back end stalls while the result register is full; reset is synchronous, no clearing pass.
module ordered_list_engine_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [olist_pkg::OP_W-1:0]            in_tuser,   // opcode
  input  logic [olist_pkg::TDATA_IN_W-1:0]      in_tdata,   // position, value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [olist_pkg::TDATA_OUT_W-1:0]     out_tdata,  // status, element_value,
                                                            // element_count, found
  output logic                                  out_tlast   // last_of_run
);
  import olist_pkg::*;

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  res_t res;

  olist_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  olist_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {res.found, res.element_count, res.element_value, res.status};
  assign out_tlast = res.last_of_run;

endmodule

FILE: rtl/olist_front.sv
// Front end: accepts input words, decodes the opcode and queues commands.
`include "assert_macros.svh"

module olist_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [olist_pkg::OP_W-1:0]           in_tuser,  // opcode
  input  logic [olist_pkg::TDATA_IN_W-1:0]     in_tdata,  // position, value
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output olist_pkg::cmd_t                      q_cmd
);
  import olist_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic            push;
  logic            pop;
  cmd_t            dec;

  always_comb begin
    dec.pos   = in_tdata[POS_W-1:0];
    dec.value = in_tdata[POS_W+VAL_W-1:POS_W];
    case (in_tuser)
      OP_INS_END:   dec.kind = K_INS_END;
      OP_INS_BEGIN: dec.kind = K_INS_BEGIN;
      OP_INS_POS:   dec.kind = K_INS_POS;
      OP_DEL_FIRST: dec.kind = K_DEL_FIRST;
      OP_DEL_LAST:  dec.kind = K_DEL_LAST;
      OP_DEL_POS:   dec.kind = K_DEL_POS;
      OP_SEARCH:    dec.kind = K_SEARCH;
      OP_DUMP:      dec.kind = K_DUMP;
      OP_CLEAR:     dec.kind = K_CLEAR;
      OP_COUNT:     dec.kind = K_NOP;
      default:      dec.kind = K_NOP;
    endcase
  end

  assign in_tready = (cnt_r != Q_CW'(Q_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_cmd     = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

  `OLE_CHECK(a_q_bound, clk, rst_n, cnt_r <= Q_CW'(Q_DEPTH))
  `OLE_CHECK(a_q_fill, clk, rst_n, (push && !pop) |=> (cnt_r == $past(cnt_r) + Q_CW'(1)))
  `OLE_CHECK(a_q_drain, clk, rst_n, (pop && !push) |=> (cnt_r + Q_CW'(1) == $past(cnt_r)))

endmodule

FILE: rtl/olist_back.sv
// Back end: cell row with circular rotate, insert and pop, plus result register.
`include "assert_macros.svh"

module olist_back #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  olist_pkg::cmd_t   q_cmd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output olist_pkg::res_t   out_res
);
  import olist_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {S_IDLE, S_ROT, S_POP, S_FIX, S_SCAN} state_t;
  typedef enum logic [1:0] {ROW_HOLD, ROW_INS, ROW_ROT, ROW_SHL} row_op_t;

  logic signed [VAL_W-1:0] cell_r   [CAPACITY];
  logic signed [VAL_W-1:0] cell_nxt [CAPACITY];

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   step_r, step_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            found_r, found_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r, res_nxt;

  row_op_t                 row_op;
  logic [CW-1:0]           row_idx;
  logic signed [VAL_W-1:0] row_val;

  logic out_free;
  logic take;

  assign out_free   = !out_valid_r || out_tready;
  assign take       = (state_r == S_IDLE) && q_valid && out_free;
  assign q_ready    = take;
  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

  always_comb begin
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CW-1:0]   rem;
    logic            hit;
    logic            emit;
    status_t         e_status;
    logic signed [VAL_W-1:0] e_value;
    logic            e_found;
    logic            e_last;

    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    cmd_nxt   = cmd_r;
    row_op    = ROW_HOLD;
    row_idx   = '0;
    row_val   = q_cmd.value;
    pos_x     = CMPW'(q_cmd.pos);
    cnt_x     = CMPW'(count_r);
    rem       = CW'(count_r - CW'(1)) - idx_r;
    hit       = (cell_r[0] == cmd_r.value);
    emit      = 1'b0;
    e_status  = ST_OK;
    e_value   = '0;
    e_found   = 1'b0;
    e_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            K_INS_END, K_INS_BEGIN, K_INS_POS: begin
              emit = 1'b1;
              if (count_r == CW'(CAPACITY)) begin
                e_status = ST_FULL;
              end else if (q_cmd.kind == K_INS_POS &&
                           (pos_x == '0 || pos_x > cnt_x + CMPW'(1))) begin
                e_status = ST_BADPOS;
              end else begin
                row_op    = ROW_INS;
                count_nxt = count_r + CW'(1);
                if (q_cmd.kind == K_INS_END) begin
                  row_idx = count_r;
                end else if (q_cmd.kind == K_INS_BEGIN) begin
                  row_idx = '0;
                end else begin
                  row_idx = CW'(pos_x - CMPW'(1));
                end
              end
            end
            K_DEL_FIRST, K_DEL_LAST, K_DEL_POS: begin
              if (count_r == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else if (q_cmd.kind == K_DEL_POS &&
                           (pos_x == '0 || pos_x > cnt_x)) begin
                emit     = 1'b1;
                e_status = ST_BADPOS;
              end else begin
                if (q_cmd.kind == K_DEL_FIRST) begin
                  idx_nxt = '0;
                end else if (q_cmd.kind == K_DEL_LAST) begin
                  idx_nxt = count_r - CW'(1);
                end else begin
                  idx_nxt = CW'(pos_x - CMPW'(1));
                end
                step_nxt  = idx_nxt;
                state_nxt = (idx_nxt == '0) ? S_POP : S_ROT;
              end
            end
            K_SEARCH, K_DUMP: begin
              if (count_r == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                step_nxt  = count_r;
                found_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            K_CLEAR: begin
              count_nxt = '0;
              emit      = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_ROT: begin
        row_op   = ROW_ROT;
        step_nxt = step_r - CW'(1);
        if (step_r == CW'(1)) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          e_value   = cell_r[0];
          row_op    = ROW_SHL;
          count_nxt = count_r - CW'(1);
          step_nxt  = rem;
          if (idx_r == '0 || rem == '0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FIX;
          end
        end
      end
      S_FIX: begin
        row_op   = ROW_ROT;
        step_nxt = step_r - CW'(1);
        if (step_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          row_op    = ROW_ROT;
          step_nxt  = step_r - CW'(1);
          found_nxt = found_r || hit;
          e_last    = (step_r == CW'(1));
          if (cmd_r.kind == K_DUMP) begin
            emit    = 1'b1;
            e_value = cell_r[0];
          end else begin
            emit    = e_last;
            e_found = found_r || hit;
          end
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt         = 1'b1;
      res_nxt.status        = e_status;
      res_nxt.element_value = e_value;
      res_nxt.element_count = CNT_W'(count_nxt);
      res_nxt.found         = e_found;
      res_nxt.last_of_run   = e_last;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CW:0] GI = (CW+1)'(g);
    localparam logic [CW:0] GN = (CW+1)'(g + 1);
    always_comb begin
      cell_nxt[g] = cell_r[g];
      case (row_op)
        ROW_INS: begin
          if (GI == {1'b0, row_idx}) begin
            cell_nxt[g] = row_val;
          end else if (GI > {1'b0, row_idx} && GI <= {1'b0, count_r}) begin
            if (g > 0) begin
              cell_nxt[g] = cell_r[(g > 0) ? g - 1 : 0];
            end
          end
        end
        ROW_ROT: begin
          if (GN < {1'b0, count_r}) begin
            cell_nxt[g] = cell_r[(g + 1 < CAPACITY) ? g + 1 : g];
          end else if (GN == {1'b0, count_r}) begin
            cell_nxt[g] = cell_r[0];
          end
        end
        ROW_SHL: begin
          if (g + 1 < CAPACITY) begin
            cell_nxt[g] = cell_r[(g + 1 < CAPACITY) ? g + 1 : g];
          end
        end
        default: begin
          cell_nxt[g] = cell_r[g];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      cell_r[g] <= cell_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  `OLE_CHECK(a_cnt_cap, clk, rst_n, count_r <= CW'(CAPACITY))
  `OLE_NEVER(a_step_live, clk, rst_n,
             (state_r == S_ROT || state_r == S_FIX || state_r == S_SCAN) && step_r == '0)
  `OLE_CHECK(a_pop_idx, clk, rst_n, (state_r == S_POP) |-> (idx_r < count_r))
  `OLE_CHECK(a_cnt_move, clk, rst_n,
             (count_r != $past(count_r)) |->
             (count_r == '0 || count_r == $past(count_r) + CW'(1) ||
              count_r + CW'(1) == $past(count_r)))

endmodule
